// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted (active low).
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

// File: rtl/msad_pkg.sv
// Shared constants for the masked SAD accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package msad_pkg;

    // Width of one pixel byte and of the packed input fields.
    localparam int BYTE_W    = 8;
    localparam int MAX_LANES = 8;
    localparam int FIELD_W   = BYTE_W * MAX_LANES;

    // Width of the running sum and of the emitted total.
    localparam int SUM_W     = 32;

    // Largest absolute difference of one byte lane.
    localparam int LANE_MAX  = 255;

    typedef logic [SUM_W-1:0] t_sum;

endpackage

`default_nettype wire

// File: rtl/msad_item_sad.sv
// Per-item SAD: optional masking, one absolute difference per byte lane and their sum.
// Depends on msad_pkg; purely combinational, used between the pipeline registers.
`default_nettype none

module msad_item_sad
    import msad_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
) (
    input  wire logic [BYTES_PER_ITEM*BYTE_W-1:0]                i_search,
    input  wire logic [BYTES_PER_ITEM*BYTE_W-1:0]                i_template,
    input  wire logic [BYTES_PER_ITEM*BYTE_W-1:0]                i_mask,
    input  wire logic                                            i_mask_en,
    output logic      [$clog2(BYTES_PER_ITEM*LANE_MAX+1)-1:0]    o_item_sad
);

    localparam int ITEM_W = $clog2(BYTES_PER_ITEM * LANE_MAX + 1);

    logic [BYTE_W-1:0] lane_diff [BYTES_PER_ITEM];

    // One masked absolute difference per byte lane.
    for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_lane
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] k;

        always_comb begin
            k = i_mask_en ? i_mask[g*BYTE_W +: BYTE_W] : {BYTE_W{1'b1}};
            a = i_search[g*BYTE_W +: BYTE_W] & k;
            b = i_template[g*BYTE_W +: BYTE_W] & k;
            lane_diff[g] = (a > b) ? (a - b) : (b - a);
        end
    end

    // Sum of the lane differences; one narrow addition per byte lane.
    always_comb begin
        o_item_sad = '0;
        for (int i = 0; i < BYTES_PER_ITEM; i++) begin
            o_item_sad = o_item_sad + ITEM_W'(lane_diff[i]);
        end
    end

endmodule

`default_nettype wire

// File: rtl/masked_sad_accumulator.sv
// Masked SAD accumulator: a last item passes the stage 1 register, and its total then
// loads the output register; one item per cycle while the input is not stalled.
// Stage 1 registers the item, stage 2 adds its SAD into the running sum and loads the
// output register on the last item. Input stall rises only when a last item waits
// behind an unconsumed total. Synchronous active-low reset empties the pipeline,
// clears the running sum and sets mask enable to 1.
`default_nettype none

module masked_sad_accumulator
    import msad_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    // Input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [FIELD_W-1:0] i_search_bytes,
    input  wire logic [FIELD_W-1:0] i_template_bytes,
    input  wire logic [FIELD_W-1:0] i_mask_bytes,
    input  wire logic               i_last_item,
    // Output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [SUM_W-1:0]        o_sad_total
);

    localparam int LANE_BITS = BYTES_PER_ITEM * BYTE_W;
    localparam int ITEM_W    = $clog2(BYTES_PER_ITEM * LANE_MAX + 1);

    logic                 r_mask_en;
    logic                 r_s1_valid;
    logic [LANE_BITS-1:0] r_s1_search;
    logic [LANE_BITS-1:0] r_s1_template;
    logic [LANE_BITS-1:0] r_s1_mask;
    logic                 r_s1_last;
    t_sum                 r_sum;
    logic                 r_out_valid;
    t_sum                 r_out_total;

    logic [ITEM_W-1:0]    item_sad;
    t_sum                 n_sum;
    logic                 out_free;
    logic                 s1_advance;
    logic                 s1_load;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_mask_en <= i_cfg_wr_data;
        end
    end

    // Pipeline flow control.
    always_comb begin
        out_free   = !r_out_valid || !i_stall;
        s1_advance = r_s1_valid && (!r_s1_last || out_free);
        s1_load    = !r_s1_valid || s1_advance;
        o_stall    = !s1_load;
    end

    // Stage 1: input item register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_s1_search   <= i_search_bytes[LANE_BITS-1:0];
            r_s1_template <= i_template_bytes[LANE_BITS-1:0];
            r_s1_mask     <= i_mask_bytes[LANE_BITS-1:0];
            r_s1_last     <= i_last_item;
        end
    end

    // Item SAD over the registered lanes.
    msad_item_sad #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_item_sad (
        .i_search   (r_s1_search),
        .i_template (r_s1_template),
        .i_mask     (r_s1_mask),
        .i_mask_en  (r_mask_en),
        .o_item_sad (item_sad)
    );

    assign n_sum = r_sum + SUM_W'(item_sad);

    // Stage 2: running sum, cleared after each last item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (s1_advance) begin
            r_sum <= r_s1_last ? '0 : n_sum;
        end
    end

    // Output register holds the total until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_last) begin
            r_out_total <= n_sum;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_sad_total = r_out_total;

endmodule

`default_nettype wire

// File: rtl/msad_checker.sv
// Port-level checks for the masked SAD accumulator, bound to the top level.
// Depends on msad_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module msad_checker
    import msad_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             o_stall,
    input  wire logic             o_valid,
    input  wire logic             i_stall,
    input  wire logic [SUM_W-1:0] o_sad_total
);

    // A stalled total stays offered and unchanged.
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_sad_total))

    // Input is held back only while a total waits on a stalled output.
    `ASSERT_RST(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

    // Reset empties the pipeline on both sides.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

bind masked_sad_accumulator msad_checker u_msad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_sad_total (o_sad_total)
);

`default_nettype wire
